### rtl/lc3_pkg.sv
// shared constants, codes and helper functions for the lc-3 instruction step core
// depends on nothing; imported by lc3_instruction_step
`default_nettype none
package lc3_pkg;

	localparam int MEM_WORDS = 65536;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int RF_WORDS  = 8;

	localparam logic [15:0] START_PC_RST = 16'h3000;
	localparam logic [15:0] KBSR_ADDR    = 16'hFE00;
	localparam logic [15:0] KBDR_ADDR    = 16'hFE02;
	localparam logic [15:0] KBSR_READY   = 16'h8000;

	localparam logic [2:0] FLAG_N = 3'b100;
	localparam logic [2:0] FLAG_Z = 3'b010;
	localparam logic [2:0] FLAG_P = 3'b001;

	localparam logic [1:0] CMD_WR   = 2'd0;
	localparam logic [1:0] CMD_RD   = 2'd1;
	localparam logic [1:0] CMD_EXEC = 2'd2;

	localparam logic [1:0] HT_NONE  = 2'd0;
	localparam logic [1:0] HT_PUTS  = 2'd1;
	localparam logic [1:0] HT_PUTSP = 2'd2;

	localparam logic [3:0] OP_BR   = 4'd0;
	localparam logic [3:0] OP_ADD  = 4'd1;
	localparam logic [3:0] OP_LD   = 4'd2;
	localparam logic [3:0] OP_ST   = 4'd3;
	localparam logic [3:0] OP_JSR  = 4'd4;
	localparam logic [3:0] OP_AND  = 4'd5;
	localparam logic [3:0] OP_LDR  = 4'd6;
	localparam logic [3:0] OP_STR  = 4'd7;
	localparam logic [3:0] OP_RTI  = 4'd8;
	localparam logic [3:0] OP_NOT  = 4'd9;
	localparam logic [3:0] OP_LDI  = 4'd10;
	localparam logic [3:0] OP_STI  = 4'd11;
	localparam logic [3:0] OP_JMP  = 4'd12;
	localparam logic [3:0] OP_RES  = 4'd13;
	localparam logic [3:0] OP_LEA  = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [7:0] TV_GETC  = 8'h20;
	localparam logic [7:0] TV_OUT   = 8'h21;
	localparam logic [7:0] TV_PUTS  = 8'h22;
	localparam logic [7:0] TV_IN    = 8'h23;
	localparam logic [7:0] TV_PUTSP = 8'h24;
	localparam logic [7:0] TV_HALT  = 8'h25;

	localparam logic [2:0] REG_R0 = 3'd0;
	localparam logic [2:0] REG_R7 = 3'd7;

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v == 16'h0000) begin
			return FLAG_Z;
		end else if (v[15]) begin
			return FLAG_N;
		end else begin
			return FLAG_P;
		end
	endfunction

	function automatic logic [MEM_AW-1:0] slot(input logic [15:0] a);
		return a[MEM_AW-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/lc3_instruction_step.sv
// lc-3 core stepped one command word at a time: memory write, memory read, execute
// a write goes straight to the result, a read waits for memory data, a stopped or
// unused word finishes at once; execute fetches, then ld, ldr, sti, ldi read an operand
// (ldi an indirect word too), getc and in also write r0; kbsr without a key skips kbdr
// acceptance: a new word is taken whenever the sequencer is idle, even while a result waits
// reset: pc = 0x3000, flags = z, not halted; no memory clearing; uses lc3_pkg, lc3_ram
`default_nettype none
module lc3_instruction_step import lc3_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// address[15:0], data[31:16], key_char[39:32], key_ready[40], zero fill
	input  wire logic [47:0] s_tdata,
	// cmd[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[15:0], pc_after[31:16], cond_flags[34:32], out_char[42:35],
	// out_valid[43], host_trap[45:44], r0_value[61:46], halted[62], fault[63]
	output logic      [63:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MWAIT = 4'd1;  // host read data returning
	localparam logic [3:0] S_DRD   = 4'd2;  // device read issue (kbsr intercepted)
	localparam logic [3:0] S_DWAIT = 4'd3;  // device read data returning
	localparam logic [3:0] S_DKB   = 4'd4;  // kbdr latch write
	localparam logic [3:0] S_GOT   = 4'd5;  // a read value is in hand
	localparam logic [3:0] S_EXEC  = 4'd6;  // registers in hand, execute
	localparam logic [3:0] S_TRAP2 = 4'd7;  // second register write of getc / in
	localparam logic [3:0] S_DONE  = 4'd8;  // hand result to output register

	// what the current device read is for
	localparam logic [1:0] PH_FETCH = 2'd0;
	localparam logic [1:0] PH_OPER  = 2'd1;
	localparam logic [1:0] PH_INDIR = 2'd2;

	logic [3:0]  state_q;
	logic [1:0]  phase_q;
	logic [15:0] addr_q;
	logic [15:0] data_q;
	logic [7:0]  key_q;
	logic        kready_q;
	logic [15:0] val_q;
	logic [15:0] ins_q;
	logic [15:0] rb_q;
	logic [15:0] pc_q;
	logic [2:0]  flags_q;
	logic        stopped_q;
	logic [15:0] r0_q;

	// per-item result fields
	logic [15:0] rd_q;
	logic [7:0]  och_q;
	logic        ovalid_q;
	logic [1:0]  htrap_q;
	logic        flt_q;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;

	// main memory port
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [MEM_AW-1:0] mem_raddr;
	logic [15:0]       mem_rdata;

	// register file: two copies share the write port for two read ports
	logic        rf_we;
	logic [2:0]  rf_waddr;
	logic [15:0] rf_wdata;
	logic        rf_flags;
	logic [2:0]  rf_ra;
	logic [2:0]  rf_rb;
	logic [15:0] rf_a_rdata;
	logic [15:0] rf_b_rdata;

	lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lc3_ram #(.WIDTH(16), .DEPTH(RF_WORDS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_ra),
		.rdata (rf_a_rdata)
	);

	lc3_ram #(.WIDTH(16), .DEPTH(RF_WORDS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_rb),
		.rdata (rf_b_rdata)
	);

	// input word unpack
	logic        s_acc;
	logic [15:0] in_addr;
	logic [15:0] in_data;
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign in_addr  = s_tdata[15:0];
	assign in_data  = s_tdata[31:16];

	// instruction decode
	logic [3:0]  op;
	logic [2:0]  dr;
	logic [15:0] off9;
	logic [15:0] off6;
	logic [15:0] off11;
	logic [15:0] imm5;
	logic [15:0] pc_off9;
	logic [15:0] base_off6;
	logic [15:0] alu_b;
	logic [15:0] alu_y;
	logic [3:0]  fop;
	logic        fstore;
	logic        dev_kb;
	logic [15:0] kbsr_val;

	assign op        = ins_q[15:12];
	assign dr        = ins_q[11:9];
	assign off9      = {{7{ins_q[8]}}, ins_q[8:0]};
	assign off6      = {{10{ins_q[5]}}, ins_q[5:0]};
	assign off11     = {{5{ins_q[10]}}, ins_q[10:0]};
	assign imm5      = {{11{ins_q[4]}}, ins_q[4:0]};
	assign pc_off9   = pc_q + off9;
	assign base_off6 = rf_a_rdata + off6;
	assign alu_b     = ins_q[5] ? imm5 : rf_b_rdata;
	assign dev_kb    = (addr_q == KBSR_ADDR);
	assign kbsr_val  = kready_q ? KBSR_READY : 16'h0000;

	// the fetched word decides which register the second read port wants
	assign fop    = val_q[15:12];
	assign fstore = (fop == OP_ST) || (fop == OP_STI) || (fop == OP_STR);
	assign rf_ra  = val_q[8:6];
	assign rf_rb  = fstore ? val_q[11:9] : val_q[2:0];

	always_comb begin
		case (op)
			OP_ADD:  alu_y = rf_a_rdata + alu_b;
			OP_AND:  alu_y = rf_a_rdata & alu_b;
			OP_NOT:  alu_y = ~rf_a_rdata;
			default: alu_y = pc_off9;
		endcase
	end

	// memory and register file port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot(addr_q);
		mem_wdata = data_q;
		mem_raddr = slot(addr_q);
		rf_we     = 1'b0;
		rf_waddr  = dr;
		rf_wdata  = alu_y;
		rf_flags  = 1'b0;
		case (state_q)
			S_IDLE: begin
				mem_raddr = slot(in_addr);
				if (s_acc && s_tuser == CMD_WR) begin
					mem_we    = 1'b1;
					mem_waddr = slot(in_addr);
					mem_wdata = in_data;
				end
			end
			S_DRD: begin
				// kbsr read refreshes the status word instead of reading it
				if (dev_kb) begin
					mem_we    = 1'b1;
					mem_waddr = slot(KBSR_ADDR);
					mem_wdata = kbsr_val;
				end
			end
			S_DKB: begin
				mem_we    = 1'b1;
				mem_waddr = slot(KBDR_ADDR);
				mem_wdata = {8'h00, key_q};
			end
			S_GOT: begin
				if (phase_q == PH_OPER && op == OP_STI) begin
					mem_we    = 1'b1;
					mem_waddr = slot(val_q);
					mem_wdata = rb_q;
				end else if ((phase_q == PH_OPER && op != OP_LDI) || phase_q == PH_INDIR) begin
					// load result write-back
					rf_we    = 1'b1;
					rf_wdata = val_q;
					rf_flags = 1'b1;
				end
			end
			S_EXEC: begin
				case (op)
					OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
						rf_we    = 1'b1;
						rf_flags = 1'b1;
					end
					OP_JSR, OP_TRAP: begin
						// link register gets the advanced pc, flags untouched
						rf_we    = 1'b1;
						rf_waddr = REG_R7;
						rf_wdata = pc_q;
					end
					OP_ST: begin
						mem_we    = 1'b1;
						mem_waddr = slot(pc_off9);
						mem_wdata = rf_b_rdata;
					end
					OP_STR: begin
						mem_we    = 1'b1;
						mem_waddr = slot(base_off6);
						mem_wdata = rf_b_rdata;
					end
					default: begin
					end
				endcase
			end
			S_TRAP2: begin
				rf_we    = 1'b1;
				rf_waddr = REG_R0;
				rf_wdata = {8'h00, key_q};
				rf_flags = 1'b1;
			end
			default: begin
			end
		endcase
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_FETCH;
			pc_q      <= START_PC_RST;
			flags_q   <= FLAG_Z;
			stopped_q <= 1'b0;
		end else begin
			if (rf_flags) begin
				flags_q <= flags_of(rf_wdata);
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						addr_q   <= in_addr;
						data_q   <= in_data;
						key_q    <= s_tdata[39:32];
						kready_q <= s_tdata[40];
						rd_q     <= 16'h0000;
						och_q    <= 8'h00;
						ovalid_q <= 1'b0;
						htrap_q  <= HT_NONE;
						flt_q    <= 1'b0;
						case (s_tuser)
							CMD_WR: begin
								rd_q    <= in_data;
								state_q <= S_DONE;
							end
							CMD_RD: begin
								state_q <= S_MWAIT;
							end
							CMD_EXEC: begin
								if (stopped_q) begin
									state_q <= S_DONE;
								end else begin
									addr_q  <= pc_q;
									phase_q <= PH_FETCH;
									state_q <= S_DRD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MWAIT: begin
					rd_q    <= mem_rdata;
					state_q <= S_DONE;
				end
				S_DRD: begin
					if (dev_kb) begin
						val_q   <= kbsr_val;
						state_q <= kready_q ? S_DKB : S_GOT;
					end else begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					val_q   <= mem_rdata;
					state_q <= S_GOT;
				end
				S_DKB: begin
					state_q <= S_GOT;
				end
				S_GOT: begin
					case (phase_q)
						PH_FETCH: begin
							ins_q   <= val_q;
							rd_q    <= val_q;
							pc_q    <= pc_q + 16'd1;
							state_q <= S_EXEC;
						end
						PH_OPER: begin
							if (op == OP_LDI) begin
								addr_q  <= val_q;
								phase_q <= PH_INDIR;
								state_q <= S_DRD;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_EXEC: begin
					rb_q    <= rf_b_rdata;
					state_q <= S_DONE;
					case (op)
						OP_BR: begin
							if ((dr & flags_q) != 3'b000) begin
								pc_q <= pc_off9;
							end
						end
						OP_JMP: begin
							pc_q <= rf_a_rdata;
						end
						OP_JSR: begin
							pc_q <= ins_q[11] ? (pc_q + off11) : rf_a_rdata;
						end
						OP_LD, OP_LDI, OP_STI: begin
							addr_q  <= pc_off9;
							phase_q <= PH_OPER;
							state_q <= S_DRD;
						end
						OP_LDR: begin
							addr_q  <= base_off6;
							phase_q <= PH_OPER;
							state_q <= S_DRD;
						end
						OP_TRAP: begin
							case (ins_q[7:0])
								TV_GETC: begin
									state_q <= S_TRAP2;
								end
								TV_OUT: begin
									och_q    <= r0_q[7:0];
									ovalid_q <= 1'b1;
								end
								TV_PUTS: begin
									htrap_q <= HT_PUTS;
								end
								TV_IN: begin
									och_q    <= key_q;
									ovalid_q <= 1'b1;
									state_q  <= S_TRAP2;
								end
								TV_PUTSP: begin
									htrap_q <= HT_PUTSP;
								end
								TV_HALT: begin
									stopped_q <= 1'b1;
								end
								default: begin
									flt_q <= 1'b1;
								end
							endcase
						end
						OP_RTI, OP_RES: begin
							flt_q <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				S_TRAP2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// start pc write also restarts the program counter
			if (cfg_we) begin
				pc_q <= cfg_wdata;
			end
		end
	end

	// shadow copy of r0 for the result word
	always_ff @(posedge clk) begin
		if (rf_we && rf_waddr == REG_R0) begin
			r0_q <= rf_wdata;
		end
	end

	// output register: holds a finished word while the next command runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= out_load | (m_tvalid_q & ~m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {flt_q, stopped_q, r0_q, htrap_q, ovalid_q, och_q,
				flags_q, pc_q, rd_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

### rtl/lc3_ram.sv
// generic synchronous ram: one write port, one read port, registered read
// no dependencies
`default_nettype none
module lc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
